### hdl/dpd_pkg.sv
// Shared types and constants for the delimited packet deframer.
// No dependencies; imported by the core, the output buffer and the top level.
package dpd_pkg;

  localparam logic [7:0] PLUS_CH  = 8'h2B;
  localparam logic [7:0] MINUS_CH = 8'h2D;

  localparam logic [15:0] HEADER_COUNT = 16'd3;
  localparam logic [15:0] TERM_COUNT   = 16'd3;
  localparam logic [1:0]  TERM_LAST    = 2'd2;

  localparam logic [8:0] TYPE_LIMIT_RESET = 9'd256;

  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_GOOD    = 3'd1;
  localparam logic [2:0] KIND_BADTYPE = 3'd2;
  localparam logic [2:0] KIND_NOTERM  = 3'd3;
  localparam logic [2:0] KIND_BADLEN  = 3'd4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] type_byte;
    logic [2:0] kind;
    logic       is_last;
  } res_t;

endpackage

### hdl/dpd_core.sv
// Frame parser: running state of the deframer, advanced once per accepted byte.
// Depends on dpd_pkg for the result type, delimiter bytes and result kinds.
module dpd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic [8:0]        type_limit,
  output logic              res_valid,
  output dpd_pkg::res_t     res
);
  import dpd_pkg::*;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_SIZE_LO = 3'd1;
  localparam logic [2:0] PH_SIZE_HI = 3'd2;
  localparam logic [2:0] PH_TYPE    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_TERM    = 3'd5;
  localparam logic [2:0] PH_SKIP    = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [15:0] recent_bytes, recent_bytes_next;
  logic [7:0]  size_lo, size_lo_next;
  logic [15:0] remaining, remaining_next;
  logic [7:0]  held_type, held_type_next;
  logic        term_ok, term_ok_next;
  logic [1:0]  term_index, term_index_next;

  logic [15:0] frame_size;
  logic [15:0] rem_dec;
  logic        bad_type;

  assign frame_size = {in_byte, size_lo};
  assign rem_dec    = remaining - 16'd1;
  assign bad_type   = (in_byte == 8'd0) || ({1'b0, in_byte} >= type_limit);

  always_comb begin
    phase_next        = phase;
    recent_bytes_next = recent_bytes;
    size_lo_next      = size_lo;
    remaining_next    = remaining;
    held_type_next    = held_type;
    term_ok_next      = term_ok;
    term_index_next   = term_index;
    res_valid         = 1'b0;
    res               = '0;
    case (phase)
      PH_SIZE_LO: begin
        size_lo_next = in_byte;
        phase_next   = PH_SIZE_HI;
      end
      PH_SIZE_HI: begin
        if (frame_size < HEADER_COUNT) begin
          held_type_next    = 8'd0;
          phase_next        = PH_HUNT;
          recent_bytes_next = 16'd0;
          res_valid         = 1'b1;
          res.kind          = KIND_BADLEN;
          res.is_last       = 1'b1;
        end else begin
          remaining_next = frame_size - HEADER_COUNT;
          phase_next     = PH_TYPE;
        end
      end
      PH_TYPE: begin
        held_type_next = in_byte;
        if (bad_type) begin
          // skip payload plus terminator slot without results
          remaining_next  = remaining + TERM_COUNT;
          phase_next      = PH_SKIP;
          res_valid       = 1'b1;
          res.type_byte   = in_byte;
          res.kind        = KIND_BADTYPE;
          res.is_last     = 1'b1;
        end else begin
          term_ok_next    = 1'b1;
          term_index_next = 2'd0;
          phase_next      = (remaining == 16'd0) ? PH_TERM : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        remaining_next = rem_dec;
        if (rem_dec == 16'd0) begin
          term_ok_next    = 1'b1;
          term_index_next = 2'd0;
          phase_next      = PH_TERM;
        end
        res_valid       = 1'b1;
        res.out_byte    = in_byte;
        res.type_byte   = held_type;
        res.kind        = KIND_PAYLOAD;
      end
      PH_TERM: begin
        if (term_index == TERM_LAST) begin
          res_valid         = 1'b1;
          res.type_byte     = held_type;
          res.kind          = (term_ok && (in_byte == MINUS_CH)) ? KIND_GOOD : KIND_NOTERM;
          res.is_last       = 1'b1;
          term_index_next   = 2'd0;
          term_ok_next      = 1'b1;
          phase_next        = PH_HUNT;
          recent_bytes_next = 16'd0;
        end else begin
          term_index_next = term_index + 2'd1;
          if (in_byte != MINUS_CH) begin
            term_ok_next = 1'b0;
          end
        end
      end
      PH_SKIP: begin
        remaining_next = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_next        = PH_HUNT;
          recent_bytes_next = 16'd0;
        end
      end
      default: begin
        // hunting; unused codes behave the same
        if (in_byte == PLUS_CH && recent_bytes == {PLUS_CH, PLUS_CH}) begin
          recent_bytes_next = 16'd0;
          phase_next        = PH_SIZE_LO;
        end else begin
          recent_bytes_next = {recent_bytes[7:0], in_byte};
          phase_next        = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      recent_bytes <= 16'd0;
      size_lo      <= 8'd0;
      remaining    <= 16'd0;
      held_type    <= 8'd0;
      term_ok      <= 1'b1;
      term_index   <= 2'd0;
    end else if (step) begin
      phase        <= phase_next;
      recent_bytes <= recent_bytes_next;
      size_lo      <= size_lo_next;
      remaining    <= remaining_next;
      held_type    <= held_type_next;
      term_ok      <= term_ok_next;
      term_index   <= term_index_next;
    end
  end

endmodule

### hdl/dpd_out_buf.sv
// Result register with a skid stage; its ready is registered, not taken from out_ready.
// Depends on dpd_pkg for the result type.
module dpd_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dpd_pkg::res_t  push_res,
  output logic           can_push,
  output logic           out_valid,
  input  logic           out_ready,
  output dpd_pkg::res_t  out_res
);
  import dpd_pkg::*;

  logic skid_valid;
  res_t skid_res;
  logic pop;

  assign pop      = out_valid && out_ready;
  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_res <= push_res;
      end else begin
        out_res <= push_res;
      end
    end
  end

endmodule

### hdl/delimited_packet_deframer_unit.sv
// Delimited packet deframer, top level: config register, parser core, output buffer.
// Depends on dpd_pkg, dpd_core and dpd_out_buf.
//
// Usage:
//   Input channel (in_valid/in_ready/in_byte) takes one link byte per request.
//   The parser hunts for "+++", reads a 16-bit little-endian size and a type
//   byte, then passes payload bytes on (kind payload) and closes each frame
//   with one is_last result: frame good, bad type, missing terminator or bad
//   length. Bad-type frame bytes are dropped without results. Output channel
//   (out_valid/out_ready) carries out_byte, type_byte, kind and is_last.
//   Config channel (cfg_valid/cfg_ready/type_limit), always ready, sets the
//   type limit; the user must write it only while the block idles (unenforced).
// Throughput:
//   One byte per cycle while in_ready is high. Each result is registered into
//   the output or skid register on the same edge that updates the parser state.
// Reset (rst, synchronous): parser returns to hunting, buffers empty,
//   type limit back to 256.
// Stall: when out_ready is low one further result is held in the skid
//   stage; in_ready then drops until the skid stage drains.
module delimited_packet_deframer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] type_limit,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [7:0] type_byte,
  output logic [2:0] kind,
  output logic       is_last
);
  import dpd_pkg::*;

  logic [8:0] type_limit_reg;
  logic       step;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_limit_reg <= TYPE_LIMIT_RESET;
    end else if (cfg_valid) begin
      type_limit_reg <= type_limit;
    end
  end

  assign step = in_valid && in_ready;

  dpd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .in_byte    (in_byte),
    .type_limit (type_limit_reg),
    .res_valid  (res_valid),
    .res        (res)
  );

  dpd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (step && res_valid),
    .push_res  (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_byte  = out_res.out_byte;
  assign type_byte = out_res.type_byte;
  assign kind      = out_res.kind;
  assign is_last   = out_res.is_last;

endmodule
